// ===== rtl/core/vgbm_pkg.sv =====
// Shared types and constants of the voxel greedy box merger.
package vgbm_pkg;

  localparam int unsigned GRID_EDGE_DEF = 16;
  localparam int unsigned ROW_BITS_W    = 16;
  localparam int unsigned COORD_W       = 4;
  localparam int unsigned END_W         = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [10:0] {
    ST_CLEAR   = 11'b000_0000_0001,
    ST_IDLE    = 11'b000_0000_0010,
    ST_SCAN_RD = 11'b000_0000_0100,
    ST_SCAN_CK = 11'b000_0000_1000,
    ST_YG_RD   = 11'b000_0001_0000,
    ST_YG_CK   = 11'b000_0010_0000,
    ST_ZG_RD   = 11'b000_0100_0000,
    ST_ZG_CK   = 11'b000_1000_0000,
    ST_CL_RD   = 11'b001_0000_0000,
    ST_CL_WR   = 11'b010_0000_0000,
    ST_FINISH  = 11'b100_0000_0000
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR,
    DP_WRITE,
    DP_SCAN,
    DP_YEXT,
    DP_ZBEGIN,
    DP_ZROW,
    DP_ZEXT,
    DP_CBEGIN,
    DP_CWRITE
  } dp_op_e;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_YEND,
    RD_ITER
  } rd_sel_e;

  typedef struct packed {
    dp_op_e  op;
    rd_sel_e rd;
    logic    res_load;
    logic    res_found;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cur_done;
    logic scan_hit;
    logic scan_end;
    logic y_can;
    logic z_can;
    logic row_full;
    logic row_last;
    logic slab_last;
  } sts_t;

endpackage

// ===== rtl/core/voxel_greedy_box_merge.sv =====
// Top level of the voxel greedy box merger.
//
// Input channel (in_valid_i/in_ready_o): op_i = 0 writes one X-row of the
// occupancy grid at (row_y_i, row_z_i) and rewinds the scan cursor; no result.
// op_i = 1 fetches the next merged box; exactly one result transfer follows.
// Output channel (out_valid_o/out_ready_i): box_found_o and the box corners,
// max corners exclusive; all zero when the grid holds no filled cell.
// A fetch scans grid rows, tests rows while growing along Y and then along Z,
// stops growth at the grid edge, clears the box from each of its rows with a
// read and a write, then loads the output register; every row read goes
// through the registered read port of the row memory.
// One item is in work at a time; the next is taken once the result is loaded.
// The output register holds a result while the receiver stalls; the next fetch
// then waits in its last step until that result is transferred.
// After reset the grid memory is zeroed one row per cycle, all GRID_EDGE^2 rows
// (256 by default), during which in_ready_o stays low.
module voxel_greedy_box_merge #(
  parameter int unsigned GridEdge = vgbm_pkg::GRID_EDGE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [vgbm_pkg::COORD_W-1:0]    row_y_i,
  input  logic [vgbm_pkg::COORD_W-1:0]    row_z_i,
  input  logic [vgbm_pkg::ROW_BITS_W-1:0] row_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            box_found_o,
  output logic [vgbm_pkg::COORD_W-1:0]    min_x_o,
  output logic [vgbm_pkg::COORD_W-1:0]    min_y_o,
  output logic [vgbm_pkg::COORD_W-1:0]    min_z_o,
  output logic [vgbm_pkg::END_W-1:0]      max_x_o,
  output logic [vgbm_pkg::END_W-1:0]      max_y_o,
  output logic [vgbm_pkg::END_W-1:0]      max_z_o
);
  import vgbm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  vgbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  vgbm_dpath #(
    .GridEdge (GridEdge)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .row_y_i     (row_y_i),
    .row_z_i     (row_z_i),
    .row_bits_i  (row_bits_i),
    .box_found_o (box_found_o),
    .min_x_o     (min_x_o),
    .min_y_o     (min_y_o),
    .min_z_o     (min_z_o),
    .max_x_o     (max_x_o),
    .max_y_o     (max_y_o),
    .max_z_o     (max_z_o)
  );

endmodule

// ===== rtl/core/vgbm_ctrl.sv =====
// Controller state machine of the voxel greedy box merger.
module vgbm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           op_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vgbm_pkg::cmd_t cmd_o,
  input  vgbm_pkg::sts_t sts_i
);
  import vgbm_pkg::*;

  state_e state_q, state_d;
  logic   found_q, found_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    found_d       = found_q;
    in_ready_o    = 1'b0;
    cmd_o.op      = DP_NOP;
    cmd_o.rd      = RD_CUR;
    cmd_o.res_load  = 1'b0;
    cmd_o.res_found = found_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = DP_CLR;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i == OP_WRITE) begin
            cmd_o.op = DP_WRITE;
          end else if (sts_i.cur_done) begin
            found_d = 1'b0;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        cmd_o.rd = RD_CUR;
        state_d  = ST_SCAN_CK;
      end
      ST_SCAN_CK: begin
        cmd_o.op = DP_SCAN;
        if (sts_i.scan_hit) begin
          found_d = 1'b1;
          state_d = ST_YG_RD;
        end else if (sts_i.scan_end) begin
          found_d = 1'b0;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_YG_RD: begin
        if (sts_i.y_can) begin
          cmd_o.rd = RD_YEND;
          state_d  = ST_YG_CK;
        end else begin
          cmd_o.op = DP_ZBEGIN;
          state_d  = ST_ZG_RD;
        end
      end
      ST_YG_CK: begin
        if (sts_i.row_full) begin
          cmd_o.op = DP_YEXT;
          state_d  = ST_YG_RD;
        end else begin
          cmd_o.op = DP_ZBEGIN;
          state_d  = ST_ZG_RD;
        end
      end
      ST_ZG_RD: begin
        if (sts_i.z_can) begin
          cmd_o.rd = RD_ITER;
          state_d  = ST_ZG_CK;
        end else begin
          cmd_o.op = DP_CBEGIN;
          state_d  = ST_CL_RD;
        end
      end
      ST_ZG_CK: begin
        if (!sts_i.row_full) begin
          cmd_o.op = DP_CBEGIN;
          state_d  = ST_CL_RD;
        end else if (sts_i.row_last) begin
          cmd_o.op = DP_ZEXT;
          state_d  = ST_ZG_RD;
        end else begin
          cmd_o.op = DP_ZROW;
          state_d  = ST_ZG_RD;
        end
      end
      ST_CL_RD: begin
        cmd_o.rd = RD_ITER;
        state_d  = ST_CL_WR;
      end
      ST_CL_WR: begin
        cmd_o.op = DP_CWRITE;
        if (sts_i.row_last && sts_i.slab_last) state_d = ST_FINISH;
        else                                   state_d = ST_CL_RD;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/vgbm_dpath.sv =====
// Datapath of the voxel greedy box merger: grid memory, cursor, box registers.
module vgbm_dpath #(
  parameter int unsigned GridEdge = vgbm_pkg::GRID_EDGE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  vgbm_pkg::cmd_t                     cmd_i,
  output vgbm_pkg::sts_t                     sts_o,
  input  logic [vgbm_pkg::COORD_W-1:0]       row_y_i,
  input  logic [vgbm_pkg::COORD_W-1:0]       row_z_i,
  input  logic [vgbm_pkg::ROW_BITS_W-1:0]    row_bits_i,
  output logic                               box_found_o,
  output logic [vgbm_pkg::COORD_W-1:0]       min_x_o,
  output logic [vgbm_pkg::COORD_W-1:0]       min_y_o,
  output logic [vgbm_pkg::COORD_W-1:0]       min_z_o,
  output logic [vgbm_pkg::END_W-1:0]         max_x_o,
  output logic [vgbm_pkg::END_W-1:0]         max_y_o,
  output logic [vgbm_pkg::END_W-1:0]         max_z_o
);
  import vgbm_pkg::*;

  localparam int unsigned AW   = $clog2(GridEdge);
  localparam int unsigned EW   = AW + 1;
  localparam int unsigned Rows = GridEdge * GridEdge;
  localparam int unsigned RAW  = $clog2(Rows);

  function automatic logic [EW-1:0] lowest_set(input logic [GridEdge:0] v);
    logic [EW-1:0] idx;
    idx = '0;
    for (int i = GridEdge; i >= 0; i--) begin
      if (v[i]) idx = EW'(i);
    end
    return idx;
  endfunction

  function automatic logic [RAW-1:0] row_addr(input logic [AW-1:0] y, input logic [AW-1:0] z);
    return RAW'(y) + RAW'(z) * RAW'(GridEdge);
  endfunction

  logic [GridEdge-1:0] mem [Rows];
  logic [GridEdge-1:0] rdata_q;
  logic                mem_we;
  logic [RAW-1:0]      mem_waddr, mem_raddr;
  logic [GridEdge-1:0] mem_wdata;

  logic [RAW-1:0]      clr_addr_q;
  logic [AW-1:0]       cur_x_q, cur_y_q, cur_z_q;
  logic                cur_done_q;
  logic [AW-1:0]       x0_q, y0_q, z0_q;
  logic [EW-1:0]       x_end_q, y_end_q, z_end_q;
  logic [GridEdge-1:0] mask_q;
  logic [AW-1:0]       it_y_q, it_z_q;

  logic                box_found_q;
  logic [COORD_W-1:0]  min_x_q, min_y_q, min_z_q;
  logic [END_W-1:0]    max_x_q, max_y_q, max_z_q;

  logic [GridEdge-1:0] ones;
  logic [GridEdge-1:0] hit_vec;
  logic                hit;
  logic [EW-1:0]       hit_x, x_end_c, nx;
  logic [GridEdge:0]   zero_vec;
  logic [GridEdge-1:0] seg;
  logic [AW-1:0]       nxt_x, nxt_y, nxt_z;
  logic                nxt_done;
  logic                wr_ok;
  logic [GridEdge-1:0] wr_row;

  // scan and x growth
  always_comb begin
    ones     = {GridEdge{1'b1}};
    hit_vec  = rdata_q & (ones << cur_x_q);
    hit      = |hit_vec;
    hit_x    = lowest_set({1'b0, hit_vec});
    zero_vec = ~{1'b0, rdata_q} & ({(GridEdge + 1){1'b1}} << hit_x);
    x_end_c  = lowest_set(zero_vec);
    seg      = (ones << hit_x) & ~(ones << x_end_c);
  end

  // cursor advance past the hit cell, or past the whole row on a miss
  always_comb begin
    nx       = hit ? (hit_x + EW'(1)) : EW'(GridEdge);
    nxt_x    = AW'(nx);
    nxt_y    = cur_y_q;
    nxt_z    = cur_z_q;
    nxt_done = 1'b0;
    if (nx == EW'(GridEdge)) begin
      nxt_x = '0;
      if (cur_y_q == AW'(GridEdge - 1)) begin
        nxt_y = '0;
        if (cur_z_q == AW'(GridEdge - 1)) begin
          nxt_z    = '0;
          nxt_done = 1'b1;
        end else begin
          nxt_z = cur_z_q + AW'(1);
        end
      end else begin
        nxt_y = cur_y_q + AW'(1);
      end
    end
  end

  assign wr_ok  = (int'(row_y_i) < int'(GridEdge)) && (int'(row_z_i) < int'(GridEdge));
  assign wr_row = GridEdge'(row_bits_i);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_addr(it_y_q, it_z_q);
    mem_wdata = rdata_q & ~mask_q;
    case (cmd_i.op)
      DP_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
      end
      DP_WRITE: begin
        mem_we    = wr_ok;
        mem_waddr = row_addr(AW'(row_y_i), AW'(row_z_i));
        mem_wdata = wr_row;
      end
      DP_CWRITE: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.rd)
      RD_CUR:  mem_raddr = row_addr(cur_y_q, cur_z_q);
      RD_YEND: mem_raddr = row_addr(AW'(y_end_q), z0_q);
      RD_ITER: mem_raddr = row_addr(it_y_q, it_z_q);
      default: mem_raddr = row_addr(cur_y_q, cur_z_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  always_comb begin
    sts_o.clr_last  = (clr_addr_q == RAW'(Rows - 1));
    sts_o.cur_done  = cur_done_q;
    sts_o.scan_hit  = hit;
    sts_o.scan_end  = (cur_y_q == AW'(GridEdge - 1)) && (cur_z_q == AW'(GridEdge - 1));
    sts_o.y_can     = (y_end_q < EW'(GridEdge));
    sts_o.z_can     = (z_end_q < EW'(GridEdge));
    sts_o.row_full  = ((rdata_q & mask_q) == mask_q);
    sts_o.row_last  = ((EW'(it_y_q) + EW'(1)) == y_end_q);
    sts_o.slab_last = ((EW'(it_z_q) + EW'(1)) == z_end_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      cur_z_q    <= '0;
      cur_done_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_CLR: begin
          clr_addr_q <= clr_addr_q + RAW'(1);
        end
        DP_WRITE: begin
          cur_x_q    <= '0;
          cur_y_q    <= '0;
          cur_z_q    <= '0;
          cur_done_q <= 1'b0;
        end
        DP_SCAN: begin
          cur_x_q    <= nxt_x;
          cur_y_q    <= nxt_y;
          cur_z_q    <= nxt_z;
          cur_done_q <= nxt_done;
        end
        default: begin
          cur_done_q <= cur_done_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_SCAN: begin
        if (hit) begin
          x0_q    <= AW'(hit_x);
          y0_q    <= cur_y_q;
          z0_q    <= cur_z_q;
          x_end_q <= x_end_c;
          y_end_q <= EW'(cur_y_q) + EW'(1);
          z_end_q <= EW'(cur_z_q) + EW'(1);
          mask_q  <= seg;
        end
      end
      DP_YEXT: begin
        y_end_q <= y_end_q + EW'(1);
      end
      DP_ZBEGIN: begin
        it_y_q <= y0_q;
        it_z_q <= AW'(z_end_q);
      end
      DP_ZROW: begin
        it_y_q <= it_y_q + AW'(1);
      end
      DP_ZEXT: begin
        z_end_q <= z_end_q + EW'(1);
        it_y_q  <= y0_q;
        it_z_q  <= it_z_q + AW'(1);
      end
      DP_CBEGIN: begin
        it_y_q <= y0_q;
        it_z_q <= z0_q;
      end
      DP_CWRITE: begin
        if (sts_o.row_last) begin
          it_y_q <= y0_q;
          it_z_q <= it_z_q + AW'(1);
        end else begin
          it_y_q <= it_y_q + AW'(1);
        end
      end
      default: begin
        it_y_q <= it_y_q;
      end
    endcase
    if (cmd_i.res_load) begin
      if (cmd_i.res_found) begin
        box_found_q <= 1'b1;
        min_x_q     <= COORD_W'(x0_q);
        min_y_q     <= COORD_W'(y0_q);
        min_z_q     <= COORD_W'(z0_q);
        max_x_q     <= END_W'(x_end_q);
        max_y_q     <= END_W'(y_end_q);
        max_z_q     <= END_W'(z_end_q);
      end else begin
        box_found_q <= 1'b0;
        min_x_q     <= '0;
        min_y_q     <= '0;
        min_z_q     <= '0;
        max_x_q     <= '0;
        max_y_q     <= '0;
        max_z_q     <= '0;
      end
    end
  end

  assign box_found_o = box_found_q;
  assign min_x_o     = min_x_q;
  assign min_y_o     = min_y_q;
  assign min_z_o     = min_z_q;
  assign max_x_o     = max_x_q;
  assign max_y_o     = max_y_q;
  assign max_z_o     = max_z_q;

endmodule

// ===== dv/vgbm_tb_pkg.sv =====
// Scoreboard package for the voxel greedy box merger testbench: box type and predictor.
package vgbm_tb_pkg;
  import vgbm_pkg::*;

  localparam int unsigned EDGE     = GRID_EDGE_DEF;
  localparam int unsigned ROW_CNT  = EDGE * EDGE;
  localparam int unsigned CELL_CNT = EDGE * EDGE * EDGE;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] min_z;
    logic [END_W-1:0]   max_x;
    logic [END_W-1:0]   max_y;
    logic [END_W-1:0]   max_z;
  } box_t;

  // n ones starting at bit lo, lo + n <= 16
  function automatic logic [ROW_BITS_W-1:0] run_mask(int unsigned lo, int unsigned n);
    logic [31:0] v;
    v = ((32'd1 << n) - 32'd1) << lo;
    return v[ROW_BITS_W-1:0];
  endfunction

  function automatic string show_box(box_t b);
    return $sformatf("found=%0d min=(%0d,%0d,%0d) max=(%0d,%0d,%0d)",
                     b.found, b.min_x, b.min_y, b.min_z, b.max_x, b.max_y, b.max_z);
  endfunction

  class box_merge_sb;
    logic [ROW_BITS_W-1:0] solid_rows [ROW_CNT];
    int unsigned           scan_pos;
    box_t                  boxes_due [$];
    bit                    last_box_found;
    int unsigned           writes_seen;
    int unsigned           fetches_seen;
    int unsigned           boxes_merged;
    int unsigned           empty_fetches;
    int unsigned           bad_results;
    int unsigned           reports;

    function new();
      foreach (solid_rows[i]) solid_rows[i] = '0;
      scan_pos       = 0;
      last_box_found = 1'b0;
      writes_seen    = 0;
      fetches_seen   = 0;
      boxes_merged   = 0;
      empty_fetches  = 0;
      bad_results    = 0;
      reports        = 0;
    endfunction

    function int unsigned pending();
      return boxes_due.size();
    endfunction

    function box_t merge_next_box();
      box_t                  b;
      int unsigned           c, x, y, z, w, h, d, i, j;
      logic [ROW_BITS_W-1:0] m;
      bit                    ok;
      b = '0;
      for (c = scan_pos; c < CELL_CNT; c++) begin
        x = c % EDGE;
        y = (c / EDGE) % EDGE;
        z = c / (EDGE * EDGE);
        if (solid_rows[y + EDGE * z][x]) begin
          w = 1;
          while (x + w < EDGE && solid_rows[y + EDGE * z][x + w]) w++;
          m = run_mask(x, w);
          h = 1;
          while (y + h < EDGE && (solid_rows[y + h + EDGE * z] & m) == m) h++;
          d  = 1;
          ok = 1'b1;
          while (ok && z + d < EDGE) begin
            for (i = 0; i < h; i++) begin
              if ((solid_rows[y + i + EDGE * (z + d)] & m) != m) ok = 1'b0;
            end
            if (ok) d++;
          end
          for (j = 0; j < d; j++) begin
            for (i = 0; i < h; i++) solid_rows[y + i + EDGE * (z + j)] &= ~m;
          end
          scan_pos       = c + 1;
          last_box_found = 1'b1;
          b.found = 1'b1;
          b.min_x = COORD_W'(x);
          b.min_y = COORD_W'(y);
          b.min_z = COORD_W'(z);
          b.max_x = END_W'(x + w);
          b.max_y = END_W'(y + h);
          b.max_z = END_W'(z + d);
          return b;
        end
      end
      scan_pos       = CELL_CNT;
      last_box_found = 1'b0;
      return b;
    endfunction

    function void note_item(logic op, logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                            logic [ROW_BITS_W-1:0] bits);
      if (op == OP_WRITE) begin
        solid_rows[{z, y}] = bits;
        scan_pos = 0;
        writes_seen++;
      end else begin
        fetches_seen++;
        boxes_due.push_back(merge_next_box());
      end
    endfunction

    function void check_box(box_t got);
      box_t want;
      bit   bad;
      if (boxes_due.size() == 0) begin
        bad_results++;
        if (reports < 10) begin
          reports++;
          $display("ERROR: result with no fetch pending: %s", show_box(got));
        end
        return;
      end
      want = boxes_due.pop_front();
      bad  = (got.found !== want.found) || (got.min_x !== want.min_x) ||
             (got.min_y !== want.min_y) || (got.min_z !== want.min_z) ||
             (got.max_x !== want.max_x) || (got.max_y !== want.max_y) ||
             (got.max_z !== want.max_z);
      if (want.found) boxes_merged++;
      else empty_fetches++;
      if (bad) begin
        bad_results++;
        if (reports < 10) begin
          reports++;
          $display("ERROR: box mismatch, expected %s, got %s", show_box(want), show_box(got));
        end
      end
    endfunction

    function int unsigned wrap_up();
      if (boxes_due.size() != 0) begin
        bad_results += boxes_due.size();
        $display("ERROR: %0d fetch results never arrived", boxes_due.size());
      end
      return bad_results;
    endfunction
  endclass

endpackage

// ===== dv/tb.sv =====
// Testbench top for the voxel greedy box merger: stimulus, handshakes and checking.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vgbm_pkg::*;
  import vgbm_tb_pkg::*;

  localparam int unsigned TOTAL_ITEMS = 1750;
  localparam int unsigned TAIL_CYCLES = 64;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  op_i        = OP_WRITE;
  logic [COORD_W-1:0]    row_y_i     = '0;
  logic [COORD_W-1:0]    row_z_i     = '0;
  logic [ROW_BITS_W-1:0] row_bits_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  box_found_o;
  logic [COORD_W-1:0]    min_x_o, min_y_o, min_z_o;
  logic [END_W-1:0]      max_x_o, max_y_o, max_z_o;

  box_merge_sb sb;
  box_t        seen_box;
  int unsigned item_count = 0;
  bit          no_idle    = 1'b0;
  int unsigned failures;

  voxel_greedy_box_merge i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .row_y_i    (row_y_i),
    .row_z_i    (row_z_i),
    .row_bits_i (row_bits_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .box_found_o(box_found_o),
    .min_x_o    (min_x_o),
    .min_y_o    (min_y_o),
    .min_z_o    (min_z_o),
    .max_x_o    (max_x_o),
    .max_y_o    (max_y_o),
    .max_z_o    (max_z_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= 31);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_box.found = box_found_o;
      seen_box.min_x = min_x_o;
      seen_box.min_y = min_y_o;
      seen_box.min_z = min_z_o;
      seen_box.max_x = max_x_o;
      seen_box.max_y = max_y_o;
      seen_box.max_z = max_z_o;
      sb.check_box(seen_box);
    end
  end

  // entered after a rising edge; returns at the edge of the transfer
  task automatic send_item(input logic op, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z, input logic [ROW_BITS_W-1:0] bits);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    row_y_i    <= y;
    row_z_i    <= z;
    row_bits_i <= bits;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(op, y, z, bits);
    item_count++;
    no_idle = (item_count >= 700) && (item_count < 1000);
  endtask

  task automatic write_row(input int unsigned y, input int unsigned z,
                           input logic [ROW_BITS_W-1:0] bits);
    send_item(OP_WRITE, COORD_W'(y), COORD_W'(z), bits);
  endtask

  task automatic fetch_box();
    send_item(OP_FETCH, COORD_W'($urandom_range(0, 15)), COORD_W'($urandom_range(0, 15)),
              ROW_BITS_W'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ROW_BITS_W-1:0] rand_row();
    logic [ROW_BITS_W-1:0] a, b;
    int unsigned           lo;
    a  = ROW_BITS_W'($urandom);
    b  = ROW_BITS_W'($urandom);
    lo = $urandom_range(0, 15);
    case ($urandom_range(0, 5))
      0: return a;
      1: return a & b;
      2: return a | b;
      3: return run_mask(lo, $urandom_range(1, 16 - lo));
      4: return '1;
      default: return a & b & ROW_BITS_W'($urandom);
    endcase
  endfunction

  task automatic put_box(input int unsigned x0, input int unsigned w,
                         input int unsigned y0, input int unsigned h,
                         input int unsigned z0, input int unsigned d);
    logic [ROW_BITS_W-1:0] bits;
    for (int unsigned dz = 0; dz < d; dz++) begin
      for (int unsigned dy = 0; dy < h; dy++) begin
        bits = run_mask(x0, w);
        if ($urandom_range(0, 3) == 0) bits |= ROW_BITS_W'($urandom);
        write_row(y0 + dy, z0 + dz, bits);
      end
    end
  endtask

  task automatic run_scene();
    int unsigned kind, x0, w, h, d;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      repeat ($urandom_range(1, 8)) write_row($urandom_range(0, 15), $urandom_range(0, 15),
                                             rand_row());
    end else if (kind < 8) begin
      repeat ($urandom_range(1, 2)) begin
        x0 = $urandom_range(0, 15);
        w  = $urandom_range(1, 16 - x0);
        h  = $urandom_range(1, 4);
        d  = $urandom_range(1, 4);
        put_box(x0, w, $urandom_range(0, 16 - h), h, $urandom_range(0, 16 - d), d);
      end
    end else begin
      h = $urandom_range(8, 16);
      d = $urandom_range(1, 2);
      put_box(0, 16, $urandom_range(0, 16 - h), h, $urandom_range(0, 16 - d), d);
    end
    if ($urandom_range(0, 4) == 0) begin
      send_item(logic'($urandom_range(0, 1)), COORD_W'($urandom_range(0, 15)),
                COORD_W'($urandom_range(0, 15)), rand_row());
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) fetch_box();
    end else begin
      do fetch_box(); while (sb.last_box_found);
      if ($urandom_range(0, 2) == 0) fetch_box();
    end
    if ($urandom_range(0, 9) == 0) drain();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty grid, then exhausted twice in a row
    fetch_box();
    fetch_box();
    // full-width row and the far corner cell
    write_row(0, 0, 16'hFFFF);
    write_row(15, 15, 16'h8000);
    fetch_box();
    fetch_box();
    fetch_box();
    // growth along Z stops at a partial row, write in the middle rewinds the scan
    write_row(0, 0, 16'h0003);
    write_row(1, 0, 16'h0003);
    write_row(0, 1, 16'h0003);
    write_row(1, 1, 16'h0001);
    fetch_box();
    fetch_box();
    write_row(7, 3, 16'h0000);
    fetch_box();
    fetch_box();
    // full-width 2x2 block at the top corner
    write_row(14, 14, 16'hFFFF);
    write_row(15, 14, 16'hFFFF);
    write_row(14, 15, 16'hFFFF);
    write_row(15, 15, 16'hFFFF);
    fetch_box();
    fetch_box();
    drain();

    while (item_count < TOTAL_ITEMS) run_scene();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    failures = sb.wrap_up();
    $display("Covered %0d row writes and %0d fetches: %0d boxes merged, %0d exhausted-grid replies.",
             sb.writes_seen, sb.fetches_seen, sb.boxes_merged, sb.empty_fetches);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d bad results", failures);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/vgbm_pkg.sv
rtl/core/vgbm_ctrl.sv
rtl/core/vgbm_dpath.sv
rtl/core/voxel_greedy_box_merge.sv
dv/vgbm_tb_pkg.sv
dv/tb.sv
